// File: hdl/lms_system_identification_top_assert.svh
// assertion macros for the lms system identification block
`ifndef LMS_SYSTEM_IDENTIFICATION_TOP_ASSERT_SVH
`define LMS_SYSTEM_IDENTIFICATION_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define LMSID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmsid assertion failed");
// next-cycle implication
`define LMSID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmsid assertion failed");
`else
`define LMSID_ASSERT_IMP(label, ante, cons)
`define LMSID_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: hdl/lmsid_pkg.sv
`default_nettype none

package lmsid_pkg;

  // filter geometry and fixed-point formats
  localparam int TAPS        = 160;
  localparam int WEIGHT_FRAC = 40;
  localparam int PLANT_FRAC  = 22;

  localparam int X_W        = 16;
  localparam int P_W        = 24;
  localparam int W_W        = 48;
  localparam int IDX_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int SHIFT_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ERR_W      = 16;

  // update pipeline depth, part of the rotating ring
  localparam int UPD_LAT  = 5;
  localparam int RING_LEN = TAPS + UPD_LAT;
  localparam int CNT_W    = $clog2(RING_LEN);

  // accumulator and error widths
  localparam int ACC_GROW = $clog2(TAPS);
  localparam int DPROD_W  = X_W + P_W;
  localparam int D_ACC_W  = DPROD_W + ACC_GROW;
  localparam int WHALF_W  = W_W / 2;
  localparam int YPROD_W  = X_W + WHALF_W + 1;
  localparam int YACC_W   = YPROD_W + ACC_GROW;
  localparam int Y_W      = YACC_W + WHALF_W;
  localparam int FE       = (WEIGHT_FRAC > PLANT_FRAC) ? WEIGHT_FRAC : PLANT_FRAC;
  localparam int D_SHIFT  = FE - PLANT_FRAC;
  localparam int Y_SHIFT  = FE - WEIGHT_FRAC;
  localparam int E_W      = ((D_ACC_W + D_SHIFT > Y_W + Y_SHIFT) ?
                             D_ACC_W + D_SHIFT : Y_W + Y_SHIFT) + 1;
  localparam int EW_W     = E_W - Y_SHIFT;
  localparam int Q_W      = E_W - FE;

  // weight update product, error split into chunks
  localparam int CHUNK_W = 25;
  localparam int NCHUNK  = (EW_W + CHUNK_W - 1) / CHUNK_W;
  localparam int EWP_W   = NCHUNK * CHUNK_W;
  localparam int M_W     = X_W + GAIN_W + 1;
  localparam int PP_W    = CHUNK_W + 1 + M_W;
  localparam int PROD_W  = EW_W + M_W;
  localparam int NW_W    = PROD_W + 1;

  typedef logic signed [X_W-1:0]        x_t;
  typedef logic signed [P_W-1:0]        p_t;
  typedef logic signed [W_W-1:0]        w_t;
  typedef logic        [IDX_W-1:0]      idx_t;
  typedef logic        [GAIN_W-1:0]     gain_t;
  typedef logic        [SHIFT_W-1:0]    shift_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic        [CNT_W-1:0]      cnt_t;
  typedef logic signed [DPROD_W-1:0]    dprod_t;
  typedef logic signed [D_ACC_W-1:0]    dacc_t;
  typedef logic signed [YPROD_W-1:0]    yprod_t;
  typedef logic signed [YACC_W-1:0]     yacc_t;
  typedef logic signed [Y_W-1:0]        y_t;
  typedef logic signed [E_W-1:0]        e_t;
  typedef logic signed [EW_W-1:0]       ew_t;
  typedef logic signed [EWP_W-1:0]      ewp_t;
  typedef logic        [Q_W-1:0]        q_t;
  typedef logic signed [M_W-1:0]        m_t;
  typedef logic signed [PP_W-1:0]       pp_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [NW_W-1:0]       nw_t;

  localparam w_t   W_MAX   = {1'b0, {(W_W-1){1'b1}}};
  localparam w_t   W_MIN   = {1'b1, {(W_W-1){1'b0}}};
  localparam err_t ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam err_t ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam q_t   Q_POS_LIM = q_t'(2**(ERR_W-1) - 1);
  localparam q_t   Q_NEG_LIM = q_t'(2**(ERR_W-1));

  localparam gain_t  GAIN_RESET  = gain_t'(22);
  localparam shift_t SHIFT_RESET = shift_t'(41);

  // configuration register indexes
  localparam cfg_idx_t CFG_STEP_GAIN  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_STEP_SHIFT = cfg_idx_t'(1);

  localparam cnt_t CNT_LAST = cnt_t'(RING_LEN - 1);
  localparam cnt_t CNT_TAPS = cnt_t'(TAPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_YSUM,
    ST_ESUM,
    ST_ROUND,
    ST_PASS2,
    ST_EMIT
  } state_t;

  // one tap: delay line sample, plant tap, adaptive weight
  typedef struct packed {
    x_t x;
    p_t p;
    w_t w;
  } tap_t;

  typedef struct packed {
    logic rot;
    logic ins;
  } cell_ctrl_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/lmsid_cell.sv
`default_nettype none

module lmsid_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  lmsid_pkg::cell_ctrl_t ctrl,
  input  logic                  p_we,
  input  lmsid_pkg::p_t         p_new,
  input  lmsid_pkg::x_t         x_left,
  input  lmsid_pkg::tap_t       right,
  output lmsid_pkg::tap_t       tap
);

  lmsid_pkg::x_t x;
  lmsid_pkg::p_t p;
  lmsid_pkg::w_t w;

  // rotate toward cell 0, or shift the sample line one place up
  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      w <= '0;
    end else if (ctrl.rot) begin
      x <= right.x;
      w <= right.w;
    end else if (ctrl.ins) begin
      x <= x_left;
    end
  end

  // plant tap, undefined until loaded
  always_ff @(posedge clk) begin
    if (ctrl.rot) begin
      p <= right.p;
    end else if (p_we) begin
      p <= p_new;
    end
  end

  assign tap = '{x: x, p: p, w: w};

endmodule

`default_nettype wire

// File: hdl/lmsid_mac.sv
`default_nettype none

module lmsid_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  lmsid_pkg::mac_ctrl_t ctrl,
  input  lmsid_pkg::tap_t      tap,
  output lmsid_pkg::dacc_t     d_acc,
  output lmsid_pkg::yacc_t     ylo_acc,
  output lmsid_pkg::yacc_t     yhi_acc
);

  logic              pv;
  lmsid_pkg::dprod_t dprod;
  lmsid_pkg::yprod_t ylo_prod;
  lmsid_pkg::yprod_t yhi_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctrl.en;
    end
  end

  // product stage; weight split in two halves
  always_ff @(posedge clk) begin
    dprod    <= tap.x * tap.p;
    ylo_prod <= tap.x * $signed({1'b0, tap.w[lmsid_pkg::WHALF_W-1:0]});
    yhi_prod <= tap.x * $signed(tap.w[lmsid_pkg::W_W-1:lmsid_pkg::WHALF_W]);
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      d_acc   <= '0;
      ylo_acc <= '0;
      yhi_acc <= '0;
    end else if (pv) begin
      d_acc   <= d_acc + lmsid_pkg::dacc_t'(dprod);
      ylo_acc <= ylo_acc + lmsid_pkg::yacc_t'(ylo_prod);
      yhi_acc <= yhi_acc + lmsid_pkg::yacc_t'(yhi_prod);
    end
  end

endmodule

`default_nettype wire

// File: hdl/lmsid_upd.sv
`default_nettype none

module lmsid_upd (
  input  logic              clk,
  input  logic              step,
  input  logic              apply,
  input  lmsid_pkg::gain_t  gain,
  input  lmsid_pkg::shift_t shift,
  input  lmsid_pkg::ew_t    ew,
  input  lmsid_pkg::tap_t   tap_in,
  output lmsid_pkg::tap_t   tap_out
);

  lmsid_pkg::tap_t   c0, c1, c2, c3, c4;
  lmsid_pkg::m_t     m0;
  lmsid_pkg::pp_t    pp [lmsid_pkg::NCHUNK];
  lmsid_pkg::prod_t  prod;
  lmsid_pkg::prod_t  sh;
  lmsid_pkg::ewp_t   ewp;
  lmsid_pkg::prod_t  prod_sum;
  lmsid_pkg::nw_t    nw;
  logic              ovf_pos;
  logic              ovf_neg;
  lmsid_pkg::w_t     wsat;

  assign ewp = lmsid_pkg::ewp_t'(ew);

  // recombine chunk products
  always_comb begin
    prod_sum = '0;
    for (int k = 0; k < lmsid_pkg::NCHUNK; k++) begin
      prod_sum = prod_sum + (lmsid_pkg::prod_t'(pp[k]) <<< (k * lmsid_pkg::CHUNK_W));
    end
  end

  // new weight with saturation to the weight range
  always_comb begin
    nw      = lmsid_pkg::nw_t'(c3.w) + lmsid_pkg::nw_t'(sh);
    ovf_pos = !nw[lmsid_pkg::NW_W-1] && (|nw[lmsid_pkg::NW_W-1:lmsid_pkg::W_W-1]);
    ovf_neg = nw[lmsid_pkg::NW_W-1] && !(&nw[lmsid_pkg::NW_W-1:lmsid_pkg::W_W-1]);
    if (ovf_pos) begin
      wsat = lmsid_pkg::W_MAX;
    end else if (ovf_neg) begin
      wsat = lmsid_pkg::W_MIN;
    end else begin
      wsat = nw[lmsid_pkg::W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      c0   <= tap_in;
      m0   <= tap_in.x * $signed({1'b0, gain});
      c1   <= c0;
      for (int k = 0; k < lmsid_pkg::NCHUNK; k++) begin
        if (k == lmsid_pkg::NCHUNK - 1) begin
          pp[k] <= $signed(ewp[k*lmsid_pkg::CHUNK_W +: lmsid_pkg::CHUNK_W]) * m0;
        end else begin
          pp[k] <= $signed({1'b0, ewp[k*lmsid_pkg::CHUNK_W +: lmsid_pkg::CHUNK_W]}) * m0;
        end
      end
      c2   <= c1;
      prod <= prod_sum;
      c3   <= c2;
      sh   <= prod >>> shift;
      c4   <= '{x: c3.x, p: c3.p, w: apply ? wsat : c3.w};
    end
  end

  assign tap_out = c4;

endmodule

`default_nettype wire

// File: hdl/lms_system_identification_top.sv
`default_nettype none
// LMS system identification: a fixed plant FIR (Q1.22 taps, loaded one at a time with
// mode 1) and an adaptive FIR (Q7.40 weights) see the same 160-tap sample line. Each
// sample beat (mode 0) gives one result beat: the error d - y truncated toward zero and
// clipped to 16 bits, with saturated set when clipped; a load beat gives no result and
// leaves the input open for the next beat. For each sample the tap state sits in a ring
// of 160 cells plus the 5-stage weight update pipeline, and the ring is rotated twice,
// one full turn each, first for the two FIR sums through the multiply-accumulate unit at
// cell 0, then for the weight update, with the YSUM, ESUM and ROUND states in between to
// form y, the error and the rounded output, and the EMIT state to hand the result over.
// Input is stalled while a sample is in work; a finished result waits in the output
// register while the next beat is taken. Configuration writes are taken in any cycle outside reset.
`include "lms_system_identification_top_assert.svh"

module lms_system_identification_top (
  input  logic                   clk,
  input  logic                   rst,
  // input beats
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   mode,
  input  lmsid_pkg::x_t          sample_in,
  input  lmsid_pkg::idx_t        coef_index,
  input  lmsid_pkg::p_t          coef_value,
  // result beats
  output logic                   result_valid,
  input  logic                   result_stall,
  output lmsid_pkg::err_t        error_out,
  output logic                   saturated,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lmsid_pkg::cfg_idx_t    cfg_index,
  input  lmsid_pkg::cfg_data_t   cfg_data
);

  lmsid_pkg::state_t     state, state_next;
  lmsid_pkg::cnt_t       cnt;
  lmsid_pkg::gain_t      step_gain;
  lmsid_pkg::shift_t     step_shift;

  logic                  accept;
  logic                  load_result;
  logic                  plant_we;
  logic                  upd_apply;
  lmsid_pkg::cell_ctrl_t cell_ctrl;
  lmsid_pkg::mac_ctrl_t  mac_ctrl;

  lmsid_pkg::tap_t       taps [lmsid_pkg::TAPS];
  lmsid_pkg::tap_t       ring_tail;

  lmsid_pkg::dacc_t      d_acc;
  lmsid_pkg::yacc_t      ylo_acc;
  lmsid_pkg::yacc_t      yhi_acc;
  lmsid_pkg::y_t         y_sum;
  lmsid_pkg::e_t         e_val;
  lmsid_pkg::ew_t        ew;

  logic                  round_neg;
  lmsid_pkg::e_t         round_mag;
  lmsid_pkg::q_t         round_q;
  logic                  round_sat;
  lmsid_pkg::err_t       round_val;
  lmsid_pkg::err_t       res_err;
  logic                  res_sat;

  // input side is open only when the engine is idle and out of reset
  assign item_stall = rst || (state != lmsid_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain  <= lmsid_pkg::GAIN_RESET;
      step_shift <= lmsid_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lmsid_pkg::CFG_STEP_GAIN:  step_gain  <= lmsid_pkg::gain_t'(cfg_data);
        lmsid_pkg::CFG_STEP_SHIFT: step_shift <= lmsid_pkg::shift_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      lmsid_pkg::ST_IDLE: begin
        if (accept && !mode) begin
          state_next = lmsid_pkg::ST_PASS1;
        end
      end
      lmsid_pkg::ST_PASS1: begin
        if (cnt == lmsid_pkg::CNT_LAST) begin
          state_next = lmsid_pkg::ST_YSUM;
        end
      end
      lmsid_pkg::ST_YSUM:  state_next = lmsid_pkg::ST_ESUM;
      lmsid_pkg::ST_ESUM:  state_next = lmsid_pkg::ST_ROUND;
      lmsid_pkg::ST_ROUND: state_next = lmsid_pkg::ST_PASS2;
      lmsid_pkg::ST_PASS2: begin
        if (cnt == lmsid_pkg::CNT_LAST) begin
          state_next = lmsid_pkg::ST_EMIT;
        end
      end
      lmsid_pkg::ST_EMIT: begin
        // wait until the output register is free
        if (!result_valid || !result_stall) begin
          state_next = lmsid_pkg::ST_IDLE;
        end
      end
      default: state_next = lmsid_pkg::ST_IDLE;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    cell_ctrl.rot = (state == lmsid_pkg::ST_PASS1) || (state == lmsid_pkg::ST_PASS2);
    cell_ctrl.ins = accept && !mode;
    mac_ctrl.clr  = accept && !mode;
    mac_ctrl.en   = (state == lmsid_pkg::ST_PASS1) && (cnt < lmsid_pkg::CNT_TAPS);
    upd_apply     = (state == lmsid_pkg::ST_PASS2);
    plant_we      = accept && mode;
    load_result   = (state == lmsid_pkg::ST_EMIT) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmsid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // rotation counter, wraps once per full turn of the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cell_ctrl.rot) begin
      cnt <= (cnt == lmsid_pkg::CNT_LAST) ? '0 : cnt + 1'b1;
    end
  end

  // chain of tap cells; cell 0 feeds the mac and the update pipeline,
  // the last cell is refilled from the pipeline tail
  for (genvar i = 0; i < lmsid_pkg::TAPS; i++) begin : g_cell
    lmsid_pkg::tap_t right;
    lmsid_pkg::x_t   left_x;
    logic            we;

    if (i == lmsid_pkg::TAPS - 1) begin : g_last
      assign right = ring_tail;
    end else begin : g_mid
      assign right = taps[i+1];
    end

    // new sample enters at cell 0, the line moves one place up
    if (i == 0) begin : g_head
      assign left_x = sample_in;
    end else begin : g_body
      assign left_x = taps[i-1].x;
    end

    // loads with an index past the last tap match no cell
    assign we = plant_we && (int'(coef_index) == i);

    lmsid_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (cell_ctrl),
      .p_we   (we),
      .p_new  (coef_value),
      .x_left (left_x),
      .right  (right),
      .tap    (taps[i])
    );
  end

  // plant and adaptive sums, accumulated during the first turn
  lmsid_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .tap     (taps[0]),
    .d_acc   (d_acc),
    .ylo_acc (ylo_acc),
    .yhi_acc (yhi_acc)
  );

  // weight update, live during the second turn, pass-through in the first
  lmsid_upd u_upd (
    .clk     (clk),
    .step    (cell_ctrl.rot),
    .apply   (upd_apply),
    .gain    (step_gain),
    .shift   (step_shift),
    .ew      (ew),
    .tap_in  (taps[0]),
    .tap_out (ring_tail)
  );

  // y from its two halves, then the error at the common fraction point
  always_ff @(posedge clk) begin
    if (state == lmsid_pkg::ST_YSUM) begin
      y_sum <= (lmsid_pkg::y_t'(yhi_acc) <<< lmsid_pkg::WHALF_W) + lmsid_pkg::y_t'(ylo_acc);
    end
    if (state == lmsid_pkg::ST_ESUM) begin
      e_val <= (lmsid_pkg::e_t'(d_acc) <<< lmsid_pkg::D_SHIFT)
             - (lmsid_pkg::e_t'(y_sum) <<< lmsid_pkg::Y_SHIFT);
    end
  end

  // error at the weight fraction point, floored
  assign ew = lmsid_pkg::ew_t'(e_val >>> lmsid_pkg::Y_SHIFT);

  // integer error: truncate toward zero, then clip to 16 bits
  always_comb begin
    round_neg = e_val[lmsid_pkg::E_W-1];
    round_mag = round_neg ? -e_val : e_val;
    round_q   = round_mag[lmsid_pkg::E_W-1:lmsid_pkg::FE];
    round_sat = round_neg ? (round_q > lmsid_pkg::Q_NEG_LIM)
                          : (round_q > lmsid_pkg::Q_POS_LIM);
    if (round_sat) begin
      round_val = round_neg ? lmsid_pkg::ERR_MIN : lmsid_pkg::ERR_MAX;
    end else if (round_neg) begin
      round_val = ~round_q[lmsid_pkg::ERR_W-1:0] + 1'b1;
    end else begin
      round_val = round_q[lmsid_pkg::ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == lmsid_pkg::ST_ROUND) begin
      res_err <= round_val;
      res_sat <= round_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      error_out <= res_err;
      saturated <= res_sat;
    end
  end

  // a result beat only ever appears from the hand-over state
  `LMSID_ASSERT_IMP(a_result_from_emit, $rose(result_valid), $past(state) == lmsid_pkg::ST_EMIT)
  // an accepted sample always starts the first turn
  `LMSID_ASSERT_NXT(a_sample_starts, accept && !mode, state == lmsid_pkg::ST_PASS1)
  // the update turn starts aligned, right after rounding
  `LMSID_ASSERT_IMP(a_pass2_aligned, state == lmsid_pkg::ST_PASS2 && cnt == '0, $past(state) == lmsid_pkg::ST_ROUND)

endmodule

`default_nettype wire
